@@ src/fcte_pkg.sv @@
// ----------------------------------------------------------------------------
// fcte_pkg
// Types, codes and mode tables shared by the cluster table engine modules.
// ----------------------------------------------------------------------------
package fcte_pkg;

	localparam int EntryW = 28;
	localparam int IndexW = 16;
	localparam int CountW = 17;

	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_ALLOC = 2'd2;
	localparam logic [1:0] FUNC_FREE  = 2'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_MODE = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;
	localparam logic [1:0] STATUS_RANGE    = 2'd3;

	localparam logic [1:0] MODE_FAT12 = 2'd0;
	localparam logic [1:0] MODE_FAT16 = 2'd1;
	localparam logic [1:0] MODE_FAT32 = 2'd2;
	localparam logic [1:0] MODE_BAD   = 2'd3;

	localparam logic [0:0] REG_TABLE_MODE     = 1'd0;
	localparam logic [0:0] REG_ENTRIES_IN_USE = 1'd1;

	typedef struct packed {
		logic [1:0]        func;
		logic [IndexW-1:0] entry_index;
		logic [EntryW-1:0] entry_value;
	} req_t;

	typedef struct packed {
		logic [EntryW-1:0] read_value;
		logic              end_of_chain;
		logic              bad_cluster;
		logic [IndexW-1:0] allocated_index;
		logic [1:0]        status;
	} rsp_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_SCAN
	} ctrl_state_t;

	typedef struct packed {
		logic clear_step;
		logic capture;
		logic op_done;
		logic scan_start;
		logic scan_next;
		logic alloc_done;
		logic full_done;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic scan_go;
		logic hit;
		logic scan_end;
		logic out_free;
	} dp_stat_t;

	function automatic logic [EntryW-1:0] mode_mask(input logic [1:0] m);
		unique case (m)
			MODE_FAT12: mode_mask = 28'h0000FFF;
			MODE_FAT16: mode_mask = 28'h000FFFF;
			default:    mode_mask = 28'hFFFFFFF;
		endcase
	endfunction

	function automatic logic [EntryW-1:0] mode_eoc(input logic [1:0] m);
		unique case (m)
			MODE_FAT12: mode_eoc = 28'h0000FF8;
			MODE_FAT16: mode_eoc = 28'h000FFF8;
			default:    mode_eoc = 28'hFFFFFF8;
		endcase
	endfunction

	function automatic logic [EntryW-1:0] mode_bad(input logic [1:0] m);
		unique case (m)
			MODE_FAT12: mode_bad = 28'h0000FF7;
			MODE_FAT16: mode_bad = 28'h000FFF7;
			default:    mode_bad = 28'hFFFFFF7;
		endcase
	endfunction

endpackage

@@ src/fcte_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcte_ctrl
// Sequencer for the cluster table: clearing pass, item capture, execution
// and first-fit allocation scan.
// ----------------------------------------------------------------------------
module fcte_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  fcte_pkg::dp_stat_t stat,
	output fcte_pkg::dp_cmd_t  cmd
);

	fcte_pkg::ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcte_pkg::S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fcte_pkg::S_CLEAR: begin
				if (stat.clear_last) state_nxt = fcte_pkg::S_IDLE;
			end
			fcte_pkg::S_IDLE: begin
				if (req_valid) state_nxt = fcte_pkg::S_EXEC;
			end
			fcte_pkg::S_EXEC: begin
				if (stat.scan_go) begin
					state_nxt = fcte_pkg::S_SCAN;
				end else if (stat.out_free) begin
					state_nxt = fcte_pkg::S_IDLE;
				end
			end
			fcte_pkg::S_SCAN: begin
				if ((stat.hit || stat.scan_end) && stat.out_free) begin
					state_nxt = fcte_pkg::S_IDLE;
				end
			end
			default: state_nxt = fcte_pkg::S_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			fcte_pkg::S_CLEAR: begin
				cmd.clear_step = 1'b1;
			end
			fcte_pkg::S_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			fcte_pkg::S_EXEC: begin
				cmd.scan_start = stat.scan_go;
				cmd.op_done    = !stat.scan_go && stat.out_free;
			end
			fcte_pkg::S_SCAN: begin
				cmd.alloc_done = stat.hit && stat.out_free;
				cmd.full_done  = !stat.hit && stat.scan_end && stat.out_free;
				cmd.scan_next  = !stat.hit && !stat.scan_end;
			end
			default: begin
				cmd       = '0;
				req_stall = 1'b1;
			end
		endcase
	end

	// at most one datapath action per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("fcte_ctrl: conflicting datapath commands");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == fcte_pkg::S_EXEC)
		else $error("fcte_ctrl: captured item not executed");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fcte_pkg::S_CLEAR |-> req_stall)
		else $error("fcte_ctrl: item taken during clearing pass");

endmodule

@@ src/fcte_dp.sv @@
// ----------------------------------------------------------------------------
// fcte_dp
// Datapath: configuration registers, entry memory, item registers, scan
// counters and the result register.
// ----------------------------------------------------------------------------
module fcte_dp #(
	parameter int MAX_ENTRIES = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [0:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	input  fcte_pkg::req_t     req,
	output fcte_pkg::rsp_t     rsp,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	input  fcte_pkg::dp_cmd_t  cmd,
	output fcte_pkg::dp_stat_t stat
);

	localparam int Depth = (MAX_ENTRIES < 65536) ? MAX_ENTRIES : 65536;
	localparam int AW = $clog2(Depth);
	localparam logic [fcte_pkg::CountW-1:0] DepthW = fcte_pkg::CountW'(Depth);
	localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

	logic [1:0]                    mode_q;
	logic [fcte_pkg::CountW-1:0]   entries_q;
	logic [fcte_pkg::CountW-1:0]   bound;

	logic [fcte_pkg::EntryW-1:0]   mem [Depth];
	logic [fcte_pkg::EntryW-1:0]   rdata_q;
	logic                          mem_re;
	logic [AW-1:0]                 mem_raddr;
	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [fcte_pkg::EntryW-1:0]   mem_wdata;

	logic [AW-1:0]                 clr_q;
	logic [1:0]                    func_q;
	logic [fcte_pkg::IndexW-1:0]   idx_q;
	logic [fcte_pkg::EntryW-1:0]   val_q;
	logic [fcte_pkg::CountW-1:0]   scan_q;
	logic [AW-1:0]                 chk_s1;

	logic [fcte_pkg::EntryW-1:0]   mask;
	logic [fcte_pkg::EntryW-1:0]   rv;
	logic                          bad_mode;
	logic                          in_range;
	logic                          put_item;
	logic                          rsp_load;
	fcte_pkg::rsp_t                op_rsp;
	fcte_pkg::rsp_t                rsp_nxt;
	fcte_pkg::rsp_t                rsp_q;
	logic                          rsp_valid_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= fcte_pkg::MODE_FAT16;
			entries_q <= 17'h10000;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				fcte_pkg::REG_TABLE_MODE:     mode_q    <= cfg_data[1:0];
				fcte_pkg::REG_ENTRIES_IN_USE: entries_q <= cfg_data;
				default:                      mode_q    <= mode_q;
			endcase
		end
	end

	assign bound    = (entries_q < DepthW) ? entries_q : DepthW;
	assign mask     = fcte_pkg::mode_mask(mode_q);
	assign bad_mode = (mode_q == fcte_pkg::MODE_BAD);
	assign in_range = ({1'b0, idx_q} < bound);
	assign put_item = cmd.op_done && !bad_mode && in_range
		&& ((func_q == fcte_pkg::FUNC_WRITE) || (func_q == fcte_pkg::FUNC_FREE));

	// item and scan registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= req.func;
			idx_q  <= req.entry_index;
			val_q  <= req.entry_value;
		end
		if (cmd.scan_start) begin
			scan_q <= fcte_pkg::CountW'(3);
			chk_s1 <= AW'(2);
		end else if (cmd.scan_next) begin
			scan_q <= scan_q + 1'b1;
			chk_s1 <= scan_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// entry memory ports
	always_comb begin
		mem_re    = cmd.capture || cmd.scan_start || cmd.scan_next;
		mem_raddr = req.entry_index[AW-1:0];
		if (cmd.scan_start) begin
			mem_raddr = AW'(2);
		end else if (cmd.scan_next) begin
			mem_raddr = scan_q[AW-1:0];
		end
		mem_we    = cmd.clear_step || put_item || cmd.alloc_done;
		mem_waddr = clr_q;
		mem_wdata = '0;
		if (put_item) begin
			mem_waddr = idx_q[AW-1:0];
			mem_wdata = (func_q == fcte_pkg::FUNC_WRITE) ? (val_q & mask) : '0;
		end else if (cmd.alloc_done) begin
			mem_waddr = chk_s1;
			mem_wdata = fcte_pkg::mode_eoc(mode_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// result of a single-step item
	assign rv = rdata_q & mask;

	always_comb begin
		op_rsp = '0;
		priority if (bad_mode) begin
			op_rsp.status = fcte_pkg::STATUS_BAD_MODE;
		end else if (func_q == fcte_pkg::FUNC_ALLOC) begin
			op_rsp.status = fcte_pkg::STATUS_FULL;
		end else if (!in_range) begin
			op_rsp.status = fcte_pkg::STATUS_RANGE;
		end else if (func_q == fcte_pkg::FUNC_READ) begin
			op_rsp.read_value   = rv;
			op_rsp.end_of_chain = (rv >= fcte_pkg::mode_eoc(mode_q));
			op_rsp.bad_cluster  = (rv == fcte_pkg::mode_bad(mode_q));
			op_rsp.status       = fcte_pkg::STATUS_OK;
		end else begin
			op_rsp.status = fcte_pkg::STATUS_OK;
		end
	end

	always_comb begin
		rsp_nxt = op_rsp;
		if (cmd.alloc_done) begin
			rsp_nxt                 = '0;
			rsp_nxt.allocated_index = fcte_pkg::IndexW'(chk_s1);
			rsp_nxt.status          = fcte_pkg::STATUS_OK;
		end else if (cmd.full_done) begin
			rsp_nxt        = '0;
			rsp_nxt.status = fcte_pkg::STATUS_FULL;
		end
	end

	// result register
	assign rsp_load = cmd.op_done || cmd.alloc_done || cmd.full_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign stat.clear_last = (clr_q == LastAddr);
	assign stat.scan_go    = !bad_mode && (func_q == fcte_pkg::FUNC_ALLOC)
		&& (bound > fcte_pkg::CountW'(2));
	assign stat.hit        = ((rdata_q & mask) == '0);
	assign stat.scan_end   = (scan_q >= bound);
	assign stat.out_free   = !rsp_valid_q || !rsp_stall;

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> (!rsp_valid_q || !rsp_stall))
		else $error("fcte_dp: result register overwritten");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_done |-> ((rdata_q & mask) == '0) && (chk_s1 >= AW'(2)))
		else $error("fcte_dp: allocated entry not free or reserved");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_q.status != fcte_pkg::STATUS_OK)
		|-> (rsp_q.read_value == '0) && (rsp_q.allocated_index == '0)
			&& !rsp_q.end_of_chain && !rsp_q.bad_cluster)
		else $error("fcte_dp: error result carries data");

endmodule

@@ src/fat_cluster_table_engine_unit.sv @@
// ----------------------------------------------------------------------------
// fat_cluster_table_engine_unit
// File allocation table engine: read, write, first-fit allocate and free of
// cluster entries in FAT12, FAT16 and FAT32 modes (12-, 16-, 28-bit entries).
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  req      | in        | req_valid / req_stall  | fcte_pkg::req_t
//  rsp      | out       | rsp_valid / rsp_stall  | fcte_pkg::rsp_t
//  cfg      | in        | cfg_wr_en              | cfg_index, cfg_data
//
//  read, write, free and error items: one entry memory read, plus one write
//  for an in-range write or free; allocate: the scan checks one entry per cycle
//  after reset a clearing pass zeroes all min(MAX_ENTRIES, 65536) entries of
//  the entry memory, req_stall stays high meanwhile
//  one item at a time; a result waiting under rsp_stall holds the sequencer
//  only when the next result is ready
// ----------------------------------------------------------------------------
module fat_cluster_table_engine_unit #(
	parameter int MAX_ENTRIES = 65536
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [0:0]     cfg_index,
	input  logic [16:0]    cfg_data,
	input  logic           req_valid,
	output logic           req_stall,
	input  fcte_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fcte_pkg::rsp_t rsp
);

	fcte_pkg::dp_cmd_t  cmd;
	fcte_pkg::dp_stat_t stat;

	fcte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	fcte_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
